// ===== src/tiny_mlp_backprop_trainer_macros.svh =====
// Assertion macros shared by the trainer's checker.
`ifndef TINY_MLP_BACKPROP_TRAINER_MACROS_SVH
`define TINY_MLP_BACKPROP_TRAINER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TMBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Property checked in the cycle after reset is applied.
`define TMBT_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ===== src/tmbt_pkg.sv =====
// Shared types, constants and table functions of the MLP trainer.
`timescale 1ns / 1ps
package tmbt_pkg;

  localparam logic [15:0] LR_RESET = 16'd13107;
  localparam int TRAIN_LEN = 37;
  localparam logic signed [33:0] P_MAX = 34'sd8388607;
  localparam logic signed [33:0] P_MIN = -34'sd8388608;

  // Datapath micro-operations
  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_OUT,
    W_Z0, W_Z1, W_Z2, M_IDX, W_ROM, W_H0, W_H1, W_Y,
    M_H0W4, W_ACC, M_H1W5, M_DSY, W_DS, M_ED, W_D,
    M_DH0, W_GW4, M_DH1, W_GW5, M_EE, W_ESUM,
    M_DW4, M_DW5, W_NERR, M_DSH0, M_DSH1, M_NERRDS, W_HD0, W_HD1,
    M_LR, OP_DIV_PAR, OP_UPD, OP_DIV_MSE, OP_MSE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       cap;
    logic [3:0] k;
    logic       batch;
  } cmd_t;

  typedef struct packed {
    logic is_train;
    logic cnt_full;
    logic div_busy;
  } stat_t;

  // Micro-program of one training sample
  function automatic op_t train_op(input logic [5:0] pc);
    op_t op;
    case (pc)
      6'd0:  op = W_Z0;
      6'd1:  op = M_IDX;
      6'd2:  op = W_ROM;
      6'd3:  op = W_H0;
      6'd4:  op = W_Z1;
      6'd5:  op = M_IDX;
      6'd6:  op = W_ROM;
      6'd7:  op = W_H1;
      6'd8:  op = M_H0W4;
      6'd9:  op = W_ACC;
      6'd10: op = M_H1W5;
      6'd11: op = W_Z2;
      6'd12: op = M_IDX;
      6'd13: op = W_ROM;
      6'd14: op = W_Y;
      6'd15: op = M_DSY;
      6'd16: op = W_DS;
      6'd17: op = M_ED;
      6'd18: op = W_D;
      6'd19: op = M_DH0;
      6'd20: op = W_GW4;
      6'd21: op = M_DH1;
      6'd22: op = W_GW5;
      6'd23: op = M_EE;
      6'd24: op = W_ESUM;
      6'd25: op = M_DW4;
      6'd26: op = W_NERR;
      6'd27: op = M_DSH0;
      6'd28: op = W_DS;
      6'd29: op = M_NERRDS;
      6'd30: op = W_HD0;
      6'd31: op = M_DW5;
      6'd32: op = W_NERR;
      6'd33: op = M_DSH1;
      6'd34: op = W_DS;
      6'd35: op = M_NERRDS;
      6'd36: op = W_HD1;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

  // Unsigned shift-and-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      r = {r[62:0], num[bit_i]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Sigmoid table entry k of n, evaluated at elaboration
  function automatic logic [15:0] sig_entry(input int unsigned k, input int unsigned n);
    longint off;
    longint unsigned mag, u, term, p, den, s;
    off = 2 * longint'(k) - longint'(n);
    mag = (off < 0) ? longint'(-off) : longint'(off);
    u = udiv64(mag << 30, 64'(n));
    term = 64'd1 << 30;
    p = 64'd1 << 30;
    for (int i = 1; i <= 14; i++) begin
      term = udiv64((term * u) >> 30, 64'(i));
      if ((i & 1) == 1) p = p - term;
      else p = p + term;
    end
    for (int i = 0; i < 3; i++) p = (p * p) >> 30;
    den = (64'd1 << 30) + p;
    if (off >= 0) s = udiv64((64'd1 << 46) + (den >> 1), den);
    else s = udiv64((p << 16) + (den >> 1), den);
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== src/tmbt_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps
interface tmbt_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [3:0]         param_index;
  logic signed [23:0] param_value;
  logic               in_a;
  logic               in_b;
  logic               target;
  modport source(output valid, cmd, param_index, param_value, in_a, in_b, target,
                 input ready);
  modport sink(input valid, cmd, param_index, param_value, in_a, in_b, target,
               output ready);
endinterface

interface tmbt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prediction;
  logic        batch_done;
  logic [15:0] mean_sq_error;
  modport source(output valid, prediction, batch_done, mean_sq_error, input ready);
  modport sink(input valid, prediction, batch_done, mean_sq_error, output ready);
endinterface

interface tmbt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] learn_rate;
  modport source(output valid, learn_rate, input ready);
  modport sink(input valid, learn_rate, output ready);
endinterface

// ===== src/tmbt_div.sv =====
// Division by a constant through a reciprocal multiply, floor rounding for signed dividends.
`timescale 1ns / 1ps
module tmbt_div #(
  parameter int DIVISOR = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] dividend,
  output logic signed [32:0] quotient,
  output logic               busy
);
  // magnitudes stay below 2^32, so a 33-bit reciprocal with a 32+L shift is exact
  localparam int L = $clog2(DIVISOR);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [31:0]        mag_r;
  logic               neg_r;
  logic [64:0]        prod_r;
  logic signed [32:0] q_r;
  logic [1:0]         stage_r;

  logic [32:0]        q_mag;
  logic [39:0]        back;
  logic               inexact;
  logic signed [33:0] q_pos;

  // quotient magnitude, remainder test, floor for negative dividends
  always_comb begin
    q_mag   = 33'(prod_r >> (32 + L));
    back    = 40'(q_mag) * 40'(DIVISOR);
    inexact = (back != 40'(mag_r));
    q_pos   = $signed({1'b0, q_mag}) + ((neg_r && inexact) ? 34'sd1 : 34'sd0);
  end

  // capture, multiply, then register the signed quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else if (start) begin
      mag_r   <= dividend[32] ? 32'(-dividend) : 32'(dividend);
      neg_r   <= dividend[32];
      stage_r <= 2'd1;
    end else if (stage_r == 2'd1) begin
      prod_r  <= 65'(mag_r) * 65'(RECIP);
      stage_r <= 2'd2;
    end else if (stage_r == 2'd2) begin
      q_r     <= neg_r ? 33'(-q_pos) : 33'(q_pos);
      stage_r <= 2'd0;
    end
  end

  assign quotient = q_r;
  assign busy     = (stage_r != 2'd0);
endmodule

// ===== src/tmbt_datapath.sv =====
// Datapath: parameters, accumulators, shared multiplier, sigmoid ROM, divider.
`timescale 1ns / 1ps
module tmbt_datapath import tmbt_pkg::*; #(
  parameter int BATCH = 4,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_cmd,
  input  logic [3:0]         in_param_index,
  input  logic signed [23:0] in_param_value,
  input  logic               in_a,
  input  logic               in_b,
  input  logic               in_target,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic [15:0]        out_prediction,
  output logic               out_batch_done,
  output logic [15:0]        out_mean_sq_error
);
  localparam int IW = $clog2(SIGMOID_ENTRIES);
  localparam int CW = $clog2(BATCH + 1);

  typedef logic [15:0] rom_t [SIGMOID_ENTRIES];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) t[k] = sig_entry(k, SIGMOID_ENTRIES);
    return t;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  function automatic logic signed [26:0] sx27(input logic signed [23:0] v);
    return 27'(v);
  endfunction

  // state
  logic signed [23:0] w_r [6];
  logic signed [23:0] b_r [3];
  logic signed [31:0] gw_r [6];
  logic signed [31:0] gb_r [3];
  logic [31:0]        esum_r;
  logic [CW-1:0]      cnt_r;
  logic [15:0]        lr_r;

  // captured transaction
  logic               icmd_r, ia_r, ib_r, it_r;
  logic [3:0]         iidx_r;
  logic signed [23:0] ival_r;

  // working registers
  logic signed [26:0] z_r;
  logic               clamp_lo_r, clamp_hi_r;
  logic [15:0]        sig_r, h0_r, h1_r, y_r;
  logic signed [17:0] e_r;
  logic [14:0]        ds_r;
  logic signed [15:0] d_r;
  logic signed [23:0] nerr_r;
  logic signed [41:0] acc_r;
  logic signed [65:0] prod_r;
  logic [15:0]        mse_r;
  logic [15:0]        pred_r, mse_out_r;
  logic               done_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] pshift;
  logic signed [26:0] zoff;
  logic [IW-1:0]      rom_idx;
  logic signed [42:0] s43;
  logic signed [31:0] sum_k;
  logic signed [23:0] param_k;
  logic signed [33:0] diff;
  logic signed [23:0] upd;
  logic               div_start;
  logic signed [32:0] div_in, div_q;
  logic               div_busy;

  assign pshift = prod_r[47:16];
  assign zoff   = z_r + 27'sd524288;
  assign s43    = 43'(acc_r) + $signed(prod_r[42:0]);

  always_comb begin
    rom_idx = prod_r[20 +: IW];
    if (clamp_lo_r) rom_idx = '0;
    else if (clamp_hi_r) rom_idx = IW'(SIGMOID_ENTRIES - 1);
  end

  // parameter and sum chosen by the update index
  always_comb begin
    if (cmd.k < 4'd6) begin
      sum_k   = gw_r[cmd.k[2:0]];
      param_k = w_r[cmd.k[2:0]];
    end else begin
      sum_k   = gb_r[2'(cmd.k - 4'd6)];
      param_k = b_r[2'(cmd.k - 4'd6)];
    end
    diff = 34'(param_k) - 34'(div_q);
    if (diff > P_MAX) upd = 24'(P_MAX);
    else if (diff < P_MIN) upd = 24'(P_MIN);
    else upd = 24'(diff);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      M_IDX:    begin mul_a = $signed({13'b0, zoff[19:0]}); mul_b = 33'(SIGMOID_ENTRIES); end
      M_H0W4:   begin mul_a = $signed({17'b0, h0_r}); mul_b = 33'(w_r[4]); end
      M_H1W5:   begin mul_a = $signed({17'b0, h1_r}); mul_b = 33'(w_r[5]); end
      M_DSY:    begin
        mul_a = $signed({17'b0, y_r});
        mul_b = $signed({16'b0, 17'd65536 - {1'b0, y_r}});
      end
      M_DSH0:   begin
        mul_a = $signed({17'b0, h0_r});
        mul_b = $signed({16'b0, 17'd65536 - {1'b0, h0_r}});
      end
      M_DSH1:   begin
        mul_a = $signed({17'b0, h1_r});
        mul_b = $signed({16'b0, 17'd65536 - {1'b0, h1_r}});
      end
      M_ED:     begin mul_a = 33'(e_r); mul_b = $signed({18'b0, ds_r}); end
      M_DH0:    begin mul_a = 33'(d_r); mul_b = $signed({17'b0, h0_r}); end
      M_DH1:    begin mul_a = 33'(d_r); mul_b = $signed({17'b0, h1_r}); end
      M_EE:     begin mul_a = 33'(e_r); mul_b = 33'(e_r); end
      M_DW4:    begin mul_a = 33'(d_r); mul_b = 33'(w_r[4]); end
      M_DW5:    begin mul_a = 33'(d_r); mul_b = 33'(w_r[5]); end
      M_NERRDS: begin mul_a = 33'(nerr_r); mul_b = $signed({18'b0, ds_r}); end
      M_LR:     begin mul_a = $signed({17'b0, lr_r}); mul_b = 33'(sum_k); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_start = (cmd.op == OP_DIV_PAR) || (cmd.op == OP_DIV_MSE);
  assign div_in    = (cmd.op == OP_DIV_PAR) ? 33'(pshift) : $signed({1'b0, esum_r});

  tmbt_div #(.DIVISOR(BATCH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .quotient (div_q),
    .busy     (div_busy)
  );

  // state with reset values: parameters, sums, count, step size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin w_r[i] <= '0; gw_r[i] <= '0; end
      for (int i = 0; i < 3; i++) begin b_r[i] <= '0; gb_r[i] <= '0; end
      esum_r <= '0;
      cnt_r  <= '0;
      lr_r   <= LR_RESET;
    end else begin
      if (cfg_we) lr_r <= cfg_data;
      case (cmd.op)
        OP_LOAD: begin
          if (iidx_r < 4'd6) w_r[iidx_r[2:0]] <= ival_r;
          else if (iidx_r < 4'd9) b_r[2'(iidx_r - 4'd6)] <= ival_r;
        end
        W_D:    gb_r[2] <= gb_r[2] + pshift;
        W_GW4:  gw_r[4] <= gw_r[4] + pshift;
        W_GW5:  gw_r[5] <= gw_r[5] + pshift;
        W_ESUM: esum_r  <= esum_r + prod_r[47:16];
        W_HD0: begin
          if (ia_r) gw_r[0] <= gw_r[0] + pshift;
          if (ib_r) gw_r[2] <= gw_r[2] + pshift;
          gb_r[0] <= gb_r[0] + pshift;
        end
        W_HD1: begin
          if (ia_r) gw_r[1] <= gw_r[1] + pshift;
          if (ib_r) gw_r[3] <= gw_r[3] + pshift;
          gb_r[1] <= gb_r[1] + pshift;
          cnt_r   <= cnt_r + 1'b1;
        end
        OP_UPD: begin
          if (cmd.k < 4'd6) w_r[cmd.k[2:0]] <= upd;
          else b_r[2'(cmd.k - 4'd6)] <= upd;
        end
        OP_MSE: begin
          for (int i = 0; i < 6; i++) gw_r[i] <= '0;
          for (int i = 0; i < 3; i++) gb_r[i] <= '0;
          esum_r <= '0;
          cnt_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      icmd_r <= in_cmd;
      iidx_r <= in_param_index;
      ival_r <= in_param_value;
      ia_r   <= in_a;
      ib_r   <= in_b;
      it_r   <= in_target;
    end
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      W_Z0: z_r <= (ia_r ? sx27(w_r[0]) : 27'sd0) + (ib_r ? sx27(w_r[2]) : 27'sd0)
                   + sx27(b_r[0]);
      W_Z1: z_r <= (ia_r ? sx27(w_r[1]) : 27'sd0) + (ib_r ? sx27(w_r[3]) : 27'sd0)
                   + sx27(b_r[1]);
      W_Z2: z_r <= 27'(s43 >>> 16) + sx27(b_r[2]);
      M_IDX: begin
        clamp_lo_r <= z_r < -27'sd524288;
        clamp_hi_r <= z_r >= 27'sd524288;
      end
      W_ROM:  sig_r  <= SIG_ROM[rom_idx];
      W_H0:   h0_r   <= sig_r;
      W_H1:   h1_r   <= sig_r;
      W_ACC:  acc_r  <= prod_r[41:0];
      W_Y: begin
        y_r <= sig_r;
        e_r <= $signed({2'b0, sig_r}) - (it_r ? 18'sd65536 : 18'sd0);
      end
      W_DS:   ds_r   <= prod_r[30:16];
      W_D:    d_r    <= pshift[15:0];
      W_NERR: nerr_r <= pshift[23:0];
      OP_MSE: mse_r  <= (div_q > 33'sd65535) ? 16'hFFFF : div_q[15:0];
      OP_OUT: begin
        pred_r    <= icmd_r ? y_r : 16'd0;
        done_r    <= cmd.batch;
        mse_out_r <= cmd.batch ? mse_r : 16'd0;
      end
      default: ;
    endcase
  end

  assign stat.is_train = icmd_r;
  assign stat.cnt_full = cnt_r >= CW'(BATCH);
  assign stat.div_busy = div_busy;

  assign out_prediction    = pred_r;
  assign out_batch_done    = done_r;
  assign out_mean_sq_error = mse_out_r;
endmodule

// ===== src/tmbt_ctrl.sv =====
// Controller: sequences micro-operations and runs both handshakes.
`timescale 1ns / 1ps
module tmbt_ctrl import tmbt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_TRAIN  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_UMUL   = 4'd4;
  localparam logic [3:0] S_UDIV   = 4'd5;
  localparam logic [3:0] S_UWAIT  = 4'd6;
  localparam logic [3:0] S_UWR    = 4'd7;
  localparam logic [3:0] S_MSTART = 4'd8;
  localparam logic [3:0] S_MWAIT  = 4'd9;
  localparam logic [3:0] S_MWR    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [3:0] k_r, k_nxt;
  logic       batch_r, batch_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    k_nxt     = k_r;
    batch_nxt = batch_r;
    ov_nxt    = ov_r && !out_ready;
    cmd.op    = OP_NOP;
    cmd.cap   = 1'b0;
    cmd.k     = k_r;
    cmd.batch = batch_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        batch_nxt = 1'b0;
        pc_nxt    = '0;
        if (stat.is_train) state_nxt = S_TRAIN;
        else begin
          cmd.op    = OP_LOAD;
          state_nxt = S_OUT;
        end
      end
      S_TRAIN: begin
        cmd.op = train_op(pc_r);
        pc_nxt = pc_r + 1'b1;
        if (pc_r == 6'(TRAIN_LEN - 1)) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        k_nxt = '0;
        if (stat.cnt_full) begin
          batch_nxt = 1'b1;
          state_nxt = S_UMUL;
        end else state_nxt = S_OUT;
      end
      S_UMUL: begin
        cmd.op    = M_LR;
        state_nxt = S_UDIV;
      end
      S_UDIV: begin
        cmd.op    = OP_DIV_PAR;
        state_nxt = S_UWAIT;
      end
      S_UWAIT: if (!stat.div_busy) state_nxt = S_UWR;
      S_UWR: begin
        cmd.op = OP_UPD;
        if (k_r == 4'd8) state_nxt = S_MSTART;
        else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_UMUL;
        end
      end
      S_MSTART: begin
        cmd.op    = OP_DIV_MSE;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: if (!stat.div_busy) state_nxt = S_MWR;
      S_MWR: begin
        cmd.op    = OP_MSE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // load the result register once the previous result is gone
        if (!ov_r || out_ready) begin
          cmd.op    = OP_OUT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      k_r     <= '0;
      batch_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      k_r     <= k_nxt;
      batch_r <= batch_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// ===== src/tiny_mlp_backprop_trainer.sv =====
// Top level of the 2-2-1 sigmoid MLP batch trainer.
//
// in_ch takes one transaction per item: cmd 0 loads param_index/param_value
// (weights 0-5, biases 6-8), cmd 1 trains on in_a, in_b, target.
// out_ch returns one transaction per item: prediction, batch_done and
// mean_sq_error (zero unless the sample closed a batch).
// cfg_ch writes learn_rate (Q0.16); it is always ready, write only when idle.
// One item is processed at a time, on a shared multiplier and a divider:
//   load item: captured, written to its parameter, then its result is registered;
//   train item: 37 micro-steps of forward and backward pass;
//   batch end: plus the parameter updates and the error mean, each dividing
//   by BATCH with a pipelined reciprocal multiply.
// The next item is accepted while a result still waits on out_ch; a result
// that is not taken holds its value and blocks only the following result.
// Reset (rst_n low, synchronous) clears parameters, sums and the sample
// count, sets learn_rate to 0.2 and empties the output register.
`timescale 1ns / 1ps
module tiny_mlp_backprop_trainer import tmbt_pkg::*; #(
  parameter int BATCH = 4,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input logic        clk,
  input logic        rst_n,
  tmbt_in_if.sink    in_ch,
  tmbt_out_if.source out_ch,
  tmbt_cfg_if.sink   cfg_ch
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  tmbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmbt_datapath #(
    .BATCH           (BATCH),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_ch.cmd),
    .in_param_index    (in_ch.param_index),
    .in_param_value    (in_ch.param_value),
    .in_a              (in_ch.in_a),
    .in_b              (in_ch.in_b),
    .in_target         (in_ch.target),
    .cfg_we            (cfg_ch.valid),
    .cfg_data          (cfg_ch.learn_rate),
    .out_prediction    (out_ch.prediction),
    .out_batch_done    (out_ch.batch_done),
    .out_mean_sq_error (out_ch.mean_sq_error)
  );
endmodule

// ===== src/tmbt_checker.sv =====
// Port-level assertions for the trainer, bound to the top level.
`timescale 1ns / 1ps
`include "tiny_mlp_backprop_trainer_macros.svh"
module tmbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        batch_done,
  input logic [15:0] mean_sq_error
);
  // result register empty after reset
  `TMBT_ASSERT_RST(a_rst_empty, !out_valid, "output valid after reset")
  // a stalled result stays offered
  `TMBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  // the block is busy right after taking a transaction
  `TMBT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready after accept")
  // error report only on batch completion
  `TMBT_ASSERT_NOW(a_mse_zero, out_valid && !batch_done, mean_sq_error == 16'd0,
                   "error reported without batch")
endmodule

bind tiny_mlp_backprop_trainer tmbt_checker u_tmbt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .batch_done    (out_ch.batch_done),
  .mean_sq_error (out_ch.mean_sq_error)
);
